[rtl/core/vdtc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package vdtc_pkg;

  // Input action codes
  typedef enum logic [1:0] {
    ACT_SPEED_PULSE  = 2'd0,
    ACT_ENGINE_PULSE = 2'd1,
    ACT_TICK         = 2'd2,
    ACT_UNUSED       = 2'd3
  } action_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_SPEED_GAIN   = 2'd0,
    REG_SPEED_WINDOW = 2'd1,
    REG_FUEL_WINDOW  = 2'd2,
    REG_FUEL_LIMIT   = 2'd3
  } reg_index_t;

  localparam int GainWidth    = 20;
  localparam int GainFracBits = 16;
  localparam int CountWidth   = 8;
  localparam int LevelWidth   = 4;
  localparam int InDataWidth  = 8;
  localparam int OutDataWidth = 24;

  localparam logic [GainWidth-1:0]  GainReset       = 20'd92647;
  localparam logic [CountWidth-1:0] SpeedWinReset   = 8'd2;
  localparam logic [CountWidth-1:0] FuelWinReset    = 8'd10;
  localparam logic [CountWidth-1:0] FuelLimitReset  = 8'd5;
  localparam logic [CountWidth-1:0] CountMax        = 8'd255;
  localparam logic [LevelWidth-1:0] LevelMax        = 4'd8;

  // One dashboard record
  typedef struct packed {
    logic                  stabilizer;
    logic [1:0]            gear_code;
    logic                  fuel_reserve;
    logic                  speed_updated;
    logic [CountWidth-1:0] speed_kmh;
    logic [LevelWidth-1:0] rpm_level;
  } result_t;

  // Engine pulse count to bar level (n-9 in the middle band, 12 to 16)
  function automatic logic [LevelWidth-1:0] bar_level(input logic [CountWidth-1:0] n);
    logic [LevelWidth-1:0] lvl;
    if (n <= 8'd6) begin
      lvl = 4'd0;
    end else if (n <= 8'd9) begin
      lvl = 4'd1;
    end else if (n <= 8'd11) begin
      lvl = 4'd2;
    end else if (n >= 8'd17) begin
      lvl = LevelMax;
    end else begin
      lvl = LevelWidth'(n - 8'd9);
    end
    return lvl;
  endfunction

endpackage

`default_nettype wire

[rtl/core/vehicle_dashboard_tick_conditioner.sv]
// Dashboard tick conditioner. Speed-pulse, engine-pulse and tick events arrive
// on the s_ stream, one transfer per cycle at full rate while s_tready is high.
// Pulse events only bump saturating counters and produce nothing; each tick
// produces one dashboard record, registered on the m_ stream. The counter logic
// and the 8x20 speed multiplier take each event as accepted, so the block
// sustains one event per clock while s_tready is high. A two-entry output buffer
// (output register plus skid register) lets input flow through a downstream
// stall until the skid fills; s_tready drops only while the skid register is
// occupied. The user must write configuration registers through cfg_we/cfg_addr/
// cfg_wdata only while the block is idle; the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module vehicle_dashboard_tick_conditioner (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // cfg_addr: 0 speed_gain, 1 speed_window_ticks, 2 fuel_window, 3 fuel_enter_limit
  input  wire logic                              cfg_we,
  input  wire logic [1:0]                        cfg_addr,
  input  wire logic [vdtc_pkg::GainWidth-1:0]    cfg_wdata,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // s_tdata: action[1:0], fuel_pin[2], gear_pin_one[3], gear_pin_two[4],
  // stabilizer_pin[5], zero[7:6]
  input  wire logic [vdtc_pkg::InDataWidth-1:0]  s_tdata,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // m_tdata: rpm_level[3:0], speed_kmh[11:4], speed_updated[12],
  // fuel_reserve[13], gear_code[15:14], stabilizer[16], zero[23:17]
  output logic [vdtc_pkg::OutDataWidth-1:0]      m_tdata
);
  import vdtc_pkg::*;

  localparam int ProdWidth = CountWidth + GainWidth;

  // Configuration
  logic [GainWidth-1:0]  speed_gain;
  logic [CountWidth-1:0] speed_window_ticks;
  logic [CountWidth-1:0] fuel_window;
  logic [CountWidth-1:0] fuel_enter_limit;

  // Event state
  logic [CountWidth-1:0] engine_pulse_count;
  logic [CountWidth-1:0] speed_pulse_count;
  logic [CountWidth-1:0] speed_tick_count;
  logic [CountWidth-1:0] speed_value;
  logic [CountWidth-1:0] fuel_sample_count;
  logic [CountWidth-1:0] fuel_high_count;
  logic                  reserve_flag;

  // Output buffer
  result_t out_data;
  result_t skid_data;
  logic    skid_valid;

  // Input decode
  action_t in_action;
  logic    in_fuel;
  logic    in_accept;
  logic    tick_accept;

  assign in_action   = action_t'(s_tdata[1:0]);
  assign in_fuel     = s_tdata[2];
  assign s_tready    = !skid_valid;
  assign in_accept   = s_tvalid && s_tready;
  assign tick_accept = in_accept && (in_action == ACT_TICK);

  // Speed window
  logic [CountWidth-1:0] speed_tick_next;
  logic                  speed_close;
  logic [ProdWidth-1:0]  speed_prod;
  logic [ProdWidth-GainFracBits-1:0] speed_whole;
  logic [CountWidth-1:0] speed_new;

  assign speed_tick_next = speed_tick_count + 8'd1;
  assign speed_close     = speed_tick_next >= speed_window_ticks;
  assign speed_prod      = ProdWidth'(speed_pulse_count) * ProdWidth'(speed_gain);
  assign speed_whole     = speed_prod[ProdWidth-1:GainFracBits];
  assign speed_new       = (speed_whole > (ProdWidth-GainFracBits)'(CountMax)) ?
                           CountMax : speed_whole[CountWidth-1:0];

  // Fuel qualification window
  logic [CountWidth-1:0] fuel_sample_next;
  logic [CountWidth-1:0] fuel_high_next;
  logic                  fuel_close;
  logic                  reserve_next;

  assign fuel_sample_next = fuel_sample_count + 8'd1;
  assign fuel_high_next   = fuel_high_count + CountWidth'(in_fuel);
  assign fuel_close       = fuel_sample_next >= fuel_window;

  always_comb begin
    reserve_next = reserve_flag;
    if (fuel_close) begin
      if (!reserve_flag) begin
        reserve_next = fuel_high_next <= fuel_enter_limit;
      end else if (fuel_high_next == fuel_sample_next) begin
        reserve_next = 1'b0;
      end
    end
  end

  // Record for this tick
  result_t res;

  always_comb begin
    res.rpm_level     = bar_level(engine_pulse_count);
    res.speed_kmh     = speed_close ? speed_new : speed_value;
    res.speed_updated = speed_close;
    res.fuel_reserve  = reserve_next;
    res.gear_code     = {s_tdata[4], s_tdata[3]};
    res.stabilizer    = s_tdata[5];
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_gain         <= GainReset;
      speed_window_ticks <= SpeedWinReset;
      fuel_window        <= FuelWinReset;
      fuel_enter_limit   <= FuelLimitReset;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_addr))
        REG_SPEED_GAIN:   speed_gain         <= cfg_wdata;
        REG_SPEED_WINDOW: speed_window_ticks <= cfg_wdata[CountWidth-1:0];
        REG_FUEL_WINDOW:  fuel_window        <= cfg_wdata[CountWidth-1:0];
        REG_FUEL_LIMIT:   fuel_enter_limit   <= cfg_wdata[CountWidth-1:0];
        default: ;
      endcase
    end
  end

  // Counter and flag updates per accepted event
  always_ff @(posedge clk) begin
    if (rst) begin
      engine_pulse_count <= '0;
      speed_pulse_count  <= '0;
      speed_tick_count   <= '0;
      speed_value        <= '0;
      fuel_sample_count  <= '0;
      fuel_high_count    <= '0;
      reserve_flag       <= 1'b0;
    end else if (in_accept) begin
      unique case (in_action)
        ACT_SPEED_PULSE: begin
          if (speed_pulse_count != CountMax) speed_pulse_count <= speed_pulse_count + 8'd1;
        end
        ACT_ENGINE_PULSE: begin
          if (engine_pulse_count != CountMax) engine_pulse_count <= engine_pulse_count + 8'd1;
        end
        ACT_TICK: begin
          engine_pulse_count <= '0;
          if (speed_close) begin
            speed_value       <= speed_new;
            speed_pulse_count <= '0;
            speed_tick_count  <= '0;
          end else begin
            speed_tick_count  <= speed_tick_next;
          end
          reserve_flag <= reserve_next;
          if (fuel_close) begin
            fuel_sample_count <= '0;
            fuel_high_count   <= '0;
          end else begin
            fuel_sample_count <= fuel_sample_next;
            fuel_high_count   <= fuel_high_next;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid   <= skid_valid || tick_accept;
      skid_valid <= 1'b0;
    end else if (tick_accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      out_data <= skid_valid ? skid_data : res;
    end else if (tick_accept) begin
      skid_data <= res;
    end
  end

  assign m_tdata = {(OutDataWidth - $bits(result_t))'(0), out_data};

  // Checks
  a_skid_implies_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid register occupied while output register empty");

  a_engine_cleared : assert property (@(posedge clk) disable iff (rst)
    tick_accept |=> engine_pulse_count == '0)
    else $error("engine pulse count not cleared by tick");

  a_speed_window : assert property (@(posedge clk) disable iff (rst)
    (tick_accept && speed_close) |=> (speed_tick_count == '0 && speed_pulse_count == '0))
    else $error("speed window not restarted");

  a_level_range : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_data.rpm_level <= LevelMax)
    else $error("rpm level out of range");

  a_no_result_on_pulse : assert property (@(posedge clk) disable iff (rst)
    (in_accept && in_action != ACT_TICK && !m_tvalid && !skid_valid) |=> !m_tvalid)
    else $error("result produced for a pulse event");

endmodule

`default_nettype wire

[tb/sv/vehicle_dashboard_tick_conditioner_tb.sv]
`timescale 1ns / 1ps

module vehicle_dashboard_tick_conditioner_tb;
  import vdtc_pkg::*;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // One row of the directed stimulus: an event repeated reps times
  typedef struct {
    action_t    act;
    logic [3:0] pins;     // {stabilizer, gear_two, gear_one, fuel}
    int         reps;
    bit         pinned;   // expected record typed in below
    result_t    rec;
  } stim_row_t;

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    cfg_we    = 1'b0;
  logic [1:0]              cfg_addr  = '0;
  logic [GainWidth-1:0]    cfg_wdata = '0;
  logic                    s_tvalid  = 1'b0;
  logic                    s_tready;
  // s_tdata: action[1:0], fuel_pin[2], gear_pin_one[3], gear_pin_two[4],
  // stabilizer_pin[5], zero[7:6]
  logic [InDataWidth-1:0]  s_tdata   = '0;
  logic                    m_tvalid;
  logic                    m_tready  = 1'b0;
  // m_tdata: rpm_level[3:0], speed_kmh[11:4], speed_updated[12],
  // fuel_reserve[13], gear_code[15:14], stabilizer[16], zero[23:17]
  logic [OutDataWidth-1:0] m_tdata;

  vehicle_dashboard_tick_conditioner u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted block state and register copies
  logic [GainWidth-1:0]  gain_q;
  logic [CountWidth-1:0] speed_win_q;
  logic [CountWidth-1:0] fuel_win_q;
  logic [CountWidth-1:0] fuel_limit_q;
  logic [CountWidth-1:0] engine_pulses;
  logic [CountWidth-1:0] speed_pulses;
  logic [CountWidth-1:0] speed_ticks;
  logic [CountWidth-1:0] kmh_now;
  logic [CountWidth-1:0] fuel_samples;
  logic [CountWidth-1:0] fuel_highs;
  logic                  in_reserve;

  result_t    pending_records[$];
  stim_row_t  directed_rows[$];
  bit         pinned_valid = 1'b0;
  result_t    pinned_record = '0;
  idle_mode_t idle_mode = IDLE_NONE;
  int         fuel_bias = 50;
  int         group_count = 0;
  int         mismatch_count = 0;

  // Engine pulse count to bar level
  function automatic logic [LevelWidth-1:0] rpm_bars(input logic [CountWidth-1:0] n);
    logic [CountWidth-1:0] excess;
    excess = n - 8'd9;
    if (n >= 8'd17) return LevelMax;
    if (n >= 8'd12) return excess[LevelWidth-1:0];
    if (n >= 8'd10) return 4'd2;
    if (n >= 8'd7) return 4'd1;
    return 4'd0;
  endfunction

  // Advance the predicted state by one event; returns 1 when a record is due
  function automatic bit dash_record_from_event(input logic [InDataWidth-1:0] ev,
                                                output result_t rec);
    logic [27:0] product;
    rec = '0;
    case (action_t'(ev[1:0]))
      ACT_SPEED_PULSE: begin
        if (speed_pulses != CountMax) speed_pulses = speed_pulses + 8'd1;
        return 1'b0;
      end
      ACT_ENGINE_PULSE: begin
        if (engine_pulses != CountMax) engine_pulses = engine_pulses + 8'd1;
        return 1'b0;
      end
      ACT_TICK: begin
        rec.rpm_level = rpm_bars(engine_pulses);
        engine_pulses = '0;
        // speed window
        speed_ticks = speed_ticks + 8'd1;
        if (speed_ticks >= speed_win_q) begin
          product = speed_pulses * gain_q;
          kmh_now = (product[27:GainFracBits] > 12'd255) ? CountMax
                                                          : product[23:GainFracBits];
          speed_pulses = '0;
          speed_ticks = '0;
          rec.speed_updated = 1'b1;
        end
        // fuel qualification window
        fuel_samples = fuel_samples + 8'd1;
        if (ev[2]) fuel_highs = fuel_highs + 8'd1;
        if (fuel_samples >= fuel_win_q) begin
          if (!in_reserve) in_reserve = (fuel_highs <= fuel_limit_q);
          else if (fuel_highs == fuel_samples) in_reserve = 1'b0;
          fuel_samples = '0;
          fuel_highs = '0;
        end
        rec.speed_kmh = kmh_now;
        rec.fuel_reserve = in_reserve;
        rec.gear_code = ev[4:3];
        rec.stabilizer = ev[5];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [InDataWidth-1:0] event_word(input action_t act,
                                                        input logic [3:0] pins);
    return {2'b00, pins, act};
  endfunction

  function automatic result_t dash_record(input logic [3:0] rpm, input logic [7:0] kmh,
                                          input logic upd, input logic res,
                                          input logic [1:0] gear, input logic stab);
    return {stab, gear, res, upd, kmh, rpm};
  endfunction

  function automatic void add_row(input action_t act, input logic [3:0] pins,
                                  input int reps, input bit pinned, input result_t rec);
    stim_row_t row;
    row.act = act;
    row.pins = pins;
    row.reps = reps;
    row.pinned = pinned;
    row.rec = rec;
    directed_rows.push_back(row);
  endfunction

  function automatic bit sender_idles();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 70;
      IDLE_BOTH:   return $urandom_range(0, 99) < 7;
      default:     return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
  endtask

  // Receiver stalls
  always @(negedge clk) begin
    case (idle_mode)
      IDLE_RECEIVER: m_tready <= ($urandom_range(0, 99) >= 70);
      IDLE_BOTH:     m_tready <= ($urandom_range(0, 99) >= 7);
      default:       m_tready <= 1'b1;
    endcase
  end

  // Predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    result_t pred;
    result_t got;
    result_t want;
    if (!rst && s_tvalid && s_tready) begin
      if (dash_record_from_event(s_tdata, pred))
        pending_records.push_back(pinned_valid ? pinned_record : pred);
    end
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[$bits(result_t)-1:0]);
      if (pending_records.size() == 0) begin
        report_mismatch($sformatf("record 0x%0h with none pending", got));
      end else begin
        want = pending_records.pop_front();
        check_field("rpm_level", 8'(got.rpm_level), 8'(want.rpm_level));
        check_field("speed_kmh", got.speed_kmh, want.speed_kmh);
        check_field("speed_updated", 8'(got.speed_updated), 8'(want.speed_updated));
        check_field("fuel_reserve", 8'(got.fuel_reserve), 8'(want.fuel_reserve));
        check_field("gear_code", 8'(got.gear_code), 8'(want.gear_code));
        check_field("stabilizer", 8'(got.stabilizer), 8'(want.stabilizer));
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  // hold: drop valid until every pending record has come out.
  task automatic send_event(input logic [InDataWidth-1:0] ev, input bit hold);
    if (hold) begin
      s_tvalid <= 1'b0;
      while (pending_records.size() != 0) @(negedge clk);
      @(negedge clk);
    end
    while (sender_idles()) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= ev;
    do @(posedge clk); while (s_tready !== 1'b1);
    @(negedge clk);
  endtask

  // Drain all pending records, then give trailing pulses time to land
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_records.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [GainWidth-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_SPEED_GAIN:   gain_q = val;
      REG_SPEED_WINDOW: speed_win_q = val[CountWidth-1:0];
      REG_FUEL_WINDOW:  fuel_win_q = val[CountWidth-1:0];
      default:          fuel_limit_q = val[CountWidth-1:0];
    endcase
    @(negedge clk);
  endtask

  // Random pulses of both kinds, occasional unused codes, then one tick
  task automatic random_group(inout int items);
    int n_eng;
    int n_spd;
    logic [3:0] junk;
    bit hold;
    group_count++;
    n_eng = $urandom_range(0, 18);
    n_spd = $urandom_range(0, 12);
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 4))
        0: fuel_bias = 0;
        1: fuel_bias = 20;
        2: fuel_bias = 50;
        3: fuel_bias = 90;
        default: fuel_bias = 100;
      endcase
    end
    while (n_eng + n_spd > 0) begin
      junk = 4'($urandom);
      if ($urandom_range(0, 39) == 0) send_event(event_word(ACT_UNUSED, junk), 1'b0);
      if ($urandom_range(1, n_eng + n_spd) <= n_eng) begin
        send_event(event_word(ACT_ENGINE_PULSE, junk), 1'b0);
        n_eng--;
      end else begin
        send_event(event_word(ACT_SPEED_PULSE, junk), 1'b0);
        n_spd--;
      end
      items++;
    end
    junk = 4'($urandom);
    junk[0] = ($urandom_range(0, 99) < fuel_bias);
    // sender waits for the output to drain now and then, and on every sixth group
    hold = ($urandom_range(0, 14) == 0) || (group_count % 6 == 0);
    send_event(event_word(ACT_TICK, junk), hold);
    items++;
  endtask

  initial begin
    int items;
    logic [CountWidth-1:0] fwin;

    gain_q = GainReset;
    speed_win_q = SpeedWinReset;
    fuel_win_q = FuelWinReset;
    fuel_limit_q = FuelLimitReset;
    engine_pulses = '0;
    speed_pulses = '0;
    speed_ticks = '0;
    kmh_now = '0;
    fuel_samples = '0;
    fuel_highs = '0;
    in_reserve = 1'b0;

    // Directed events at the reset register values
    add_row(ACT_TICK, 4'b0000, 1, 1'b1,
            dash_record(4'd0, 8'd0, 1'b0, 1'b0, 2'd0, 1'b0));
    add_row(ACT_ENGINE_PULSE, 4'b0000, 17, 1'b0, '0);
    add_row(ACT_TICK, 4'b0100, 1, 1'b1,
            dash_record(LevelMax, 8'd0, 1'b1, 1'b0, 2'd2, 1'b0));
    // speed counter saturates, then the product saturates
    add_row(ACT_SPEED_PULSE, 4'b1111, 256, 1'b0, '0);
    add_row(ACT_TICK, 4'b0010, 1, 1'b0, '0);
    add_row(ACT_TICK, 4'b1110, 1, 1'b1,
            dash_record(4'd0, CountMax, 1'b1, 1'b0, 2'd3, 1'b1));
    // each bar level boundary
    add_row(ACT_ENGINE_PULSE, 4'b1010, 6, 1'b0, '0);
    add_row(ACT_TICK, 4'b0001, 1, 1'b0, '0);
    add_row(ACT_ENGINE_PULSE, 4'b0101, 7, 1'b0, '0);
    add_row(ACT_TICK, 4'b0000, 1, 1'b0, '0);
    add_row(ACT_ENGINE_PULSE, 4'b0000, 9, 1'b0, '0);
    add_row(ACT_TICK, 4'b1000, 1, 1'b0, '0);
    add_row(ACT_ENGINE_PULSE, 4'b0000, 10, 1'b0, '0);
    add_row(ACT_TICK, 4'b0000, 1, 1'b0, '0);
    add_row(ACT_ENGINE_PULSE, 4'b0000, 11, 1'b0, '0);
    add_row(ACT_TICK, 4'b0100, 1, 1'b0, '0);
    add_row(ACT_ENGINE_PULSE, 4'b0000, 12, 1'b0, '0);
    add_row(ACT_TICK, 4'b0000, 1, 1'b0, '0);
    add_row(ACT_ENGINE_PULSE, 4'b0000, 16, 1'b0, '0);
    add_row(ACT_TICK, 4'b0000, 1, 1'b0, '0);
    add_row(ACT_ENGINE_PULSE, 4'b1111, 256, 1'b0, '0);
    add_row(ACT_TICK, 4'b0001, 1, 1'b0, '0);
    // unused code, a few speed pulses, then a tick with every pin high
    add_row(ACT_UNUSED, 4'b1111, 1, 1'b0, '0);
    add_row(ACT_SPEED_PULSE, 4'b0110, 3, 1'b0, '0);
    add_row(ACT_TICK, 4'b1111, 1, 1'b0, '0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      for (int r = 0; r < directed_rows[i].reps; r++) begin
        pinned_valid = directed_rows[i].pinned;
        pinned_record = directed_rows[i].rec;
        send_event(event_word(directed_rows[i].act, directed_rows[i].pins), 1'b0);
      end
    end
    pinned_valid = 1'b0;

    // Random phases, each under a register setting and an idle mode
    for (int phase = 1; phase <= 8; phase++) begin
      settle();
      case (phase)
        1: begin
          write_reg(REG_SPEED_GAIN, 20'hFFFFF);
          write_reg(REG_SPEED_WINDOW, 20'd1);
          write_reg(REG_FUEL_WINDOW, 20'd1);
          write_reg(REG_FUEL_LIMIT, 20'd0);
        end
        2: begin
          write_reg(REG_SPEED_GAIN, 20'd0);
          write_reg(REG_SPEED_WINDOW, 20'd255);
          write_reg(REG_FUEL_WINDOW, 20'd255);
          write_reg(REG_FUEL_LIMIT, 20'd255);
        end
        3: begin
          // zero windows close every tick, including the open wide windows
          write_reg(REG_SPEED_GAIN, GainReset);
          write_reg(REG_SPEED_WINDOW, 20'd0);
          write_reg(REG_FUEL_WINDOW, 20'd0);
          write_reg(REG_FUEL_LIMIT, 20'd0);
        end
        4: begin
          write_reg(REG_SPEED_WINDOW, 20'd3);
          write_reg(REG_FUEL_WINDOW, 20'd4);
          write_reg(REG_FUEL_LIMIT, 20'd2);
        end
        default: begin
          fwin = CountWidth'($urandom_range(1, 12));
          write_reg(REG_SPEED_GAIN, GainWidth'($urandom_range(0, 20'hFFFFF)));
          write_reg(REG_SPEED_WINDOW, GainWidth'($urandom_range(1, 8)));
          write_reg(REG_FUEL_WINDOW, GainWidth'(fwin));
          write_reg(REG_FUEL_LIMIT, GainWidth'($urandom_range(0, fwin)));
        end
      endcase
      cfg_we <= 1'b0;
      idle_mode = idle_mode_t'(phase % 4);
      items = 0;
      while (items < 25) random_group(items);
    end

    settle();
    repeat (20) @(posedge clk);
    if (pending_records.size() != 0)
      report_mismatch($sformatf("%0d records never came out", pending_records.size()));
    if (mismatch_count == 0) begin
      $display("vehicle_dashboard_tick_conditioner: match");
    end else begin
      $display("vehicle_dashboard_tick_conditioner: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("vehicle_dashboard_tick_conditioner: mismatch");
    $finish;
  end

endmodule

[sim.f]
rtl/core/vdtc_pkg.sv
rtl/core/vehicle_dashboard_tick_conditioner.sv
tb/sv/vehicle_dashboard_tick_conditioner_tb.sv
